>>> rtl/etr_pkg.sv
`default_nettype none

package etr_pkg;

   // counter width of the batch totals
   localparam int COUNT_BITS     = 16;

   localparam int PROB_BITS      = 16;
   localparam int MSB_BITS       = 4;
   localparam int SUM_BITS       = 24;
   localparam int OUT_COUNT_BITS = 16;
   localparam int FRAC_BITS      = 17;
   localparam int MANT_BITS      = 32;
   localparam int SQ_BITS        = 64;
   localparam int LOG_FRAC_BITS  = 24;
   localparam int LOG_STEPS      = 24;
   localparam int NEG_LOG_BITS   = 29;
   localparam int LOG_BITS       = 21;
   localparam int PROD_BITS      = 37;
   localparam int TERM_BITS      = 21;
   localparam int STEP_BITS      = 5;
   localparam int DIV_STEPS      = 17;
   localparam int NUM_BITS       = COUNT_BITS + 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_AW       = 2;
   localparam int RSP_DATA_BITS  = 80;
   localparam int RSP_PACK_BITS  = SUM_BITS + 1 + 2*OUT_COUNT_BITS + FRAC_BITS;

   localparam logic [SUM_BITS-1:0]     SUM_MAX    = '1;
   localparam logic [COUNT_BITS-1:0]   COUNT_MAX  = '1;
   localparam logic [NEG_LOG_BITS-1:0] NEG_LOG_ONE = {1'b1, {(NEG_LOG_BITS-1){1'b0}}};
   localparam logic [NEG_LOG_BITS-1:0] LOG_ROUND  = NEG_LOG_BITS'(128);
   localparam int                      LOG_SHIFT  = 8;
   localparam logic [PROD_BITS-1:0]    TERM_ROUND = PROD_BITS'(32768);
   localparam int                      TERM_SHIFT = 16;

   typedef struct packed {
      logic [PROB_BITS-1:0] prob;
      logic [MSB_BITS-1:0]  msb;
      logic                 zero;
      logic                 last_sample;
      logic                 last_batch;
   } item_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]       sample_entropy;
      logic                      above_cutoff;
      logic [OUT_COUNT_BITS-1:0] flagged_count;
      logic [OUT_COUNT_BITS-1:0] sample_count;
      logic                      batch_done;
      logic [FRAC_BITS-1:0]      batch_fraction;
   } result_type;

   typedef struct packed {
      logic                  start;
      logic [COUNT_BITS-1:0] flagged;
      logic [COUNT_BITS-1:0] samples;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [FRAC_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> rtl/etr_front.sv
`default_nettype none

module etr_front (
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [etr_pkg::PROB_BITS-1:0]  req_tdata,
   input  logic                           req_tlast,
   input  logic                           req_tuser,
   output logic                           push,
   output etr_pkg::item_type              push_item,
   input  logic                           queue_full
);
   import etr_pkg::*;

   logic [MSB_BITS-1:0] msb;

   // leading one of the probability
   always_comb begin
      msb = '0;
      for (int i = 0; i < PROB_BITS; i++) begin
         if (req_tdata[i]) begin
            msb = MSB_BITS'(i);
         end
      end
   end

   always_comb begin
      push_item.prob        = req_tdata;
      push_item.msb         = msb;
      push_item.zero        = (req_tdata == '0);
      push_item.last_sample = req_tlast;
      // batch mark only counts together with a sample mark
      push_item.last_batch  = req_tlast & req_tuser;
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

endmodule

`default_nettype wire

>>> rtl/etr_queue.sv
`default_nettype none

module etr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  etr_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output etr_pkg::item_type pop_item
);
   import etr_pkg::*;

   item_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/etr_div.sv
`default_nettype none

module etr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  etr_pkg::div_req_type div_req,
   output etr_pkg::div_rsp_type div_rsp
);
   import etr_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] den_ff, den_in;
   logic [DIV_STEPS-1:0]  low_ff, low_in;
   logic [FRAC_BITS-1:0]  quo_ff, quo_in;
   logic [NUM_BITS-1:0]   num;
   logic [COUNT_BITS:0]   trial;
   logic                  fits;

   // rounded numerator; its top part is already below the divisor
   assign num   = {div_req.flagged, 16'b0} + NUM_BITS'(div_req.samples >> 1);
   assign trial = {rem_ff, low_ff[DIV_STEPS-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = COUNT_BITS'(num >> DIV_STEPS);
         den_in  = div_req.samples;
         low_in  = num[DIV_STEPS-1:0];
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? COUNT_BITS'(trial - {1'b0, den_ff}) : COUNT_BITS'(trial);
         low_in  = {low_ff[DIV_STEPS-2:0], 1'b0};
         quo_in  = {quo_ff[FRAC_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/etr_back.sv
`default_nettype none

module etr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  etr_pkg::item_type             item,
   output logic                          item_pop,
   input  logic [etr_pkg::SUM_BITS-1:0]  cutoff,
   output etr_pkg::div_req_type          div_req,
   input  etr_pkg::div_rsp_type          div_rsp,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output etr_pkg::result_type           rsp_result
);
   import etr_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_LOG  = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_ACC  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   item_type                 item_ff, item_in;
   logic [MANT_BITS-1:0]     m_ff, m_in;
   logic [LOG_FRAC_BITS-1:0] frac_ff, frac_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [PROD_BITS-1:0]     prod_ff, prod_in;
   logic [SUM_BITS-1:0]      sum_ff, sum_in;
   logic [COUNT_BITS-1:0]    flagged_ff, flagged_in;
   logic [COUNT_BITS-1:0]    samples_ff, samples_in;
   result_type               res_ff, res_in;
   result_type               out_ff, out_in;
   logic                     out_valid_ff, out_valid_in;

   logic [STEP_BITS-1:0]     shift;
   logic [SQ_BITS-1:0]       square;
   logic [MANT_BITS:0]       square_top;
   logic [NEG_LOG_BITS-1:0]  neg_log;
   logic [LOG_BITS-1:0]      neg_log_q16;
   logic [TERM_BITS-1:0]     term;
   logic [SUM_BITS:0]        sum_wide;
   logic [SUM_BITS-1:0]      sum_sat;
   logic                     above;
   logic [COUNT_BITS-1:0]    flagged_next, samples_next;
   logic                     slot_free;

   assign shift       = STEP_BITS'(MANT_BITS - 1) - {1'b0, item.msb};
   assign square      = SQ_BITS'(m_ff) * SQ_BITS'(m_ff);
   assign square_top  = (MANT_BITS+1)'(square >> (MANT_BITS - 1));
   assign neg_log     = NEG_LOG_ONE - {1'b0, item_ff.msb, frac_ff};
   assign neg_log_q16 = LOG_BITS'((neg_log + LOG_ROUND) >> LOG_SHIFT);
   assign term        = TERM_BITS'((prod_ff + TERM_ROUND) >> TERM_SHIFT);
   assign sum_wide    = {1'b0, sum_ff} + (SUM_BITS+1)'(term);
   assign sum_sat     = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
   assign above       = (sum_sat >= cutoff);
   assign samples_next = (samples_ff == COUNT_MAX) ? samples_ff : samples_ff + 1'b1;
   assign flagged_next = (above && flagged_ff != COUNT_MAX) ? flagged_ff + 1'b1 : flagged_ff;
   assign slot_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      flagged_in   = flagged_ff;
      samples_in   = samples_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      item_pop     = 1'b0;
      div_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               item_in  = item;
               m_in     = MANT_BITS'(item.prob) << shift;
               frac_in  = '0;
               step_in  = '0;
               prod_in  = '0;
               state_in = item.zero ? ST_ACC : ST_LOG;
            end
         end
         ST_LOG: begin
            // one squaring per cycle yields one fraction bit of log2
            if (square_top[MANT_BITS]) begin
               m_in    = square_top[MANT_BITS:1];
               frac_in = {frac_ff[LOG_FRAC_BITS-2:0], 1'b1};
            end else begin
               m_in    = square_top[MANT_BITS-1:0];
               frac_in = {frac_ff[LOG_FRAC_BITS-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(LOG_STEPS - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_BITS'(item_ff.prob) * PROD_BITS'(neg_log_q16);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (!item_ff.last_sample) begin
               sum_in   = sum_sat;
               state_in = ST_IDLE;
            end else begin
               sum_in                = '0;
               res_in.sample_entropy = sum_sat;
               res_in.above_cutoff   = above;
               res_in.flagged_count  = OUT_COUNT_BITS'(flagged_next);
               res_in.sample_count   = OUT_COUNT_BITS'(samples_next);
               res_in.batch_done     = item_ff.last_batch;
               res_in.batch_fraction = '0;
               if (item_ff.last_batch) begin
                  div_req.start   = 1'b1;
                  div_req.flagged = flagged_next;
                  div_req.samples = samples_next;
                  flagged_in      = '0;
                  samples_in      = '0;
                  state_in        = ST_DIV;
               end else begin
                  flagged_in = flagged_next;
                  samples_in = samples_next;
                  state_in   = ST_EMIT;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               res_in.batch_fraction = div_rsp.quotient;
               state_in              = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         sum_ff       <= '0;
         flagged_ff   <= '0;
         samples_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         flagged_ff   <= flagged_in;
         samples_ff   <= samples_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = out_ff;

endmodule

`default_nettype wire

>>> rtl/entropy_threshold_rate.sv
// Channel   Ports      Fields (low bit up)
// request   req_*      tdata: prob[15:0]; tlast: last_of_sample; tuser: last_of_batch
// result    rsp_*      tdata: sample_entropy, above_cutoff, flagged_count, sample_count,
//                      batch_fraction; tlast: batch_done
// csr       csr_*      wdata: threshold[23:0]
//
// A nonzero probability passes the back end as load, 24 log2 squarings, multiply and
// accumulate; a zero probability goes from load straight to accumulate.
// A sample end adds a state to hand off the result, a batch end a wait for the divider.
// Four queued requests let the request side keep running while the back end works.
// Reset is synchronous: it clears the queue, the totals, the cutoff and the result slot.
// A stalled result holds in its output register; the back end waits on it only to hand the next one off.
`default_nettype none

module entropy_threshold_rate (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [etr_pkg::PROB_BITS-1:0]      req_tdata,   // prob
   input  logic                               req_tlast,
   input  logic                               req_tuser,   // last_of_batch
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // sample_entropy, above_cutoff, flagged_count, sample_count, batch_fraction, zero fill
   output logic [etr_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_wen,
   input  logic [etr_pkg::SUM_BITS-1:0]       csr_wdata
);
   import etr_pkg::*;

   logic [SUM_BITS-1:0] thresh_ff, thresh_in;
   logic                push, queue_full, pop, pop_valid;
   item_type            push_item, pop_item;
   div_req_type         div_req;
   div_rsp_type         div_rsp;
   result_type          result;

   assign thresh_in = csr_wen ? csr_wdata : thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= '0;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   etr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_item  (push_item),
      .queue_full (queue_full)
   );

   etr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   etr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   etr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item       (pop_item),
      .item_pop   (pop),
      .cutoff     (thresh_ff),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS - RSP_PACK_BITS){1'b0}},
                       result.batch_fraction,
                       result.sample_count,
                       result.flagged_count,
                       result.above_cutoff,
                       result.sample_entropy};
   assign rsp_tlast = result.batch_done;

endmodule

`default_nettype wire

>>> rtl/etr_checker.sv
`default_nettype none

module etr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [etr_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic                               rsp_tlast
);
   import etr_pkg::*;

   logic [OUT_COUNT_BITS-1:0] flagged_count, sample_count;
   logic [FRAC_BITS-1:0]      batch_fraction;

   assign flagged_count  = rsp_tdata[40:25];
   assign sample_count   = rsp_tdata[56:41];
   assign batch_fraction = rsp_tdata[73:57];

   // a stalled result keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_frac_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> batch_fraction == '0)
      else $error("fraction set outside batch end");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> batch_fraction <= FRAC_BITS'(65536))
      else $error("fraction above one");

   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> flagged_count <= sample_count && sample_count != '0)
      else $error("flagged count exceeds sample count");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind entropy_threshold_rate etr_checker u_checker (.*);

`default_nettype wire
